FILE: hdl/ist_pkg.sv
`timescale 1ns / 1ps
// Package for the integer set table: capacity, derived widths, operation and status codes.
// Used by ist_cell and integer_set_table; depends on nothing else.
package ist_pkg;

    // Number of slots in the table.
    localparam int CAPACITY = 16;

    // Width of the member count, which must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of a slot index.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Operation codes of a transaction.
    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NO_CHANGE = 2'd1,
        STATUS_FULL      = 2'd2
    } t_status;

    // Operation broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic              active;
        t_kind             kind;
        logic [31:0]       key;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  last_idx;
    } t_cell_ctrl;

endpackage

FILE: hdl/ist_cell.sv
`timescale 1ns / 1ps
// One slot of the integer set table: holds a value, compares it with the key and
// passes the hit and tail chains to its neighbors. Depends on ist_pkg.
module ist_cell
    import ist_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_index,
    input  logic              i_hit_any,
    input  logic [31:0]       i_tail_value,
    input  logic              i_hit_chain,
    input  logic [31:0]       i_tail_chain,
    output logic              o_hit_chain,
    output logic [31:0]       o_tail_chain
);

    logic [31:0] r_value;
    logic        w_occupied;
    logic        w_match;
    logic        w_is_last;
    logic        w_is_next_free;

    // The slot holds a member when its index lies below the count.
    assign w_occupied     = CNT_W'(i_index) < i_ctrl.count;
    assign w_match        = w_occupied && (r_value == i_ctrl.key);
    assign w_is_last      = w_occupied && (i_index == i_ctrl.last_idx);
    assign w_is_next_free = CNT_W'(i_index) == i_ctrl.count;

    // Hit chain runs toward higher slots, tail chain toward lower slots.
    assign o_hit_chain  = i_hit_chain | w_match;
    assign o_tail_chain = w_is_last ? r_value : i_tail_chain;

    // An insert lands in the first free slot; a remove pulls the tail value in.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.active) begin
            if (i_ctrl.kind == KIND_INSERT && !i_hit_any && w_is_next_free) begin
                r_value <= i_ctrl.key;
            end else if (i_ctrl.kind == KIND_REMOVE && w_match) begin
                r_value <= i_tail_value;
            end
        end
    end

endmodule

FILE: hdl/integer_set_table.sv
`timescale 1ns / 1ps
// Integer set table: a chain of CAPACITY slot cells searched in the compare cycle of each transaction.
// A taken start is registered into busy, which is registered into o_valid; o_valid holds for one cycle.
// A new transaction is not taken while busy is high; busy is high for the compare/update cycle.
// The compare cycle is set by the hit and tail chains running through all slot cells.
// Synchronous active-low reset empties the set; slot values are kept, but unused.
// Results cannot be stalled: each is shown for exactly one cycle. Depends on ist_pkg, ist_cell.
module integer_set_table
    import ist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic               o_found,
    output logic [1:0]         o_status,
    output logic [4:0]         o_count
);

    logic             r_busy;
    t_kind            r_kind;
    logic [31:0]      r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic             r_found;
    t_status          r_status;
    t_status          n_status;
    logic [CNT_W-1:0] r_out_count;

    t_cell_ctrl       w_ctrl;
    logic [CAPACITY:0] w_hit_chain;
    logic [31:0]      w_tail_chain [CAPACITY+1];
    logic             w_hit_any;
    logic [31:0]      w_count_wide;
    logic             w_full;

    // Accept a transaction and hold its operands for the compare cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_value;
        end
    end

    assign busy = r_busy;

    // Operation broadcast to the cells.
    always_comb begin
        w_ctrl          = '0;
        w_ctrl.active   = r_busy;
        w_ctrl.kind     = r_kind;
        w_ctrl.key      = r_key;
        w_ctrl.count    = r_count;
        w_ctrl.last_idx = IDX_W'(r_count - CNT_W'(1));
    end

    // Chain of slot cells.
    assign w_hit_chain[0]         = 1'b0;
    assign w_tail_chain[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ist_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_index      (IDX_W'(g)),
            .i_hit_any    (w_hit_any),
            .i_tail_value (w_tail_chain[0]),
            .i_hit_chain  (w_hit_chain[g]),
            .i_tail_chain (w_tail_chain[g+1]),
            .o_hit_chain  (w_hit_chain[g+1]),
            .o_tail_chain (w_tail_chain[g])
        );
    end

    assign w_hit_any = w_hit_chain[CAPACITY];
    assign w_full    = r_count == CNT_W'(CAPACITY);

    // Next count and status of the transaction in its compare cycle.
    always_comb begin
        n_count  = r_count;
        n_status = STATUS_DONE;
        unique case (r_kind)
            KIND_LOOKUP: begin
                n_status = STATUS_DONE;
            end
            KIND_INSERT: begin
                if (w_hit_any) begin
                    n_status = STATUS_NO_CHANGE;
                end else if (w_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                if (!w_hit_any) begin
                    n_status = STATUS_NO_CHANGE;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Member count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_found     <= w_hit_any;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign w_count_wide = 32'(r_out_count);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_status     = r_status;
    assign o_count      = w_count_wide[4:0];

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("member count above capacity");

    // Every compare cycle is followed by exactly one result strobe.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_valid)
        else $error("result strobe missing after compare cycle");

    // A full status is only reported when the table was full and the value absent.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && n_status == STATUS_FULL) |-> (w_full && !w_hit_any))
        else $error("full status without a full table");

    // A remove of a member shrinks the count by one.
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_kind == KIND_REMOVE && w_hit_any)
            |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not shrink the count");

endmodule
